// ===== rtl/core/ist_pkg.sv =====
package ist_pkg;

   // command codes (req_tuser)
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_SUB   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // bounds are stored biased (sign bit flipped) so unsigned order is signed order
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] UMAX     = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
   } entry_type;

   typedef struct packed {
      logic [5:0]  count;
      logic [63:0] hi;
      logic [63:0] lo;
      logic        valid;
      logic        included;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ===== rtl/core/ist_ram.sv =====
module ist_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ist_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output ist_pkg::entry_type  rd_data
);

   ist_pkg::entry_type mem [DEPTH];
   ist_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ist_ctrl.sv =====
module ist_ctrl #(
   parameter int MAX_RANGES = 32,
   parameter int AW         = 5,
   parameter int CW         = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_cmd,
   input  logic [63:0]        req_lo,
   input  logic [63:0]        req_hi,
   input  logic [4:0]         req_index,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output ist_pkg::rsp_type   rsp_data,
   output logic [AW-1:0]      rd_addr,
   input  ist_pkg::entry_type rd_data,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output ist_pkg::entry_type wr_data,
   output logic               bank_sel
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EV   = 3'd2;
   localparam logic [2:0] S_W2   = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   localparam int CMPW = (CW > 5) ? CW : 5;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               sel_ff, sel_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [63:0]        lo_ff, lo_in;
   logic [63:0]        hi_ff, hi_in;
   logic [4:0]         idx_ff, idx_in;
   logic [63:0]        nlo_ff, nlo_in;
   logic [63:0]        nhi_ff, nhi_in;
   logic               merged_ff, merged_in;
   logic               placed_ff, placed_in;
   logic               full_ff, full_in;
   logic               inval_ff, inval_in;
   logic               incl_ff, incl_in;
   ist_pkg::entry_type pend_ff, pend_in;
   ist_pkg::entry_type rdent_ff, rdent_in;
   ist_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               tbl_full;
   logic               reach_lo;
   logic               reach_hi;
   logic               cut_left;
   logic               cut_right;
   logic               slot_free;
   logic               full_add;
   logic               commit;
   logic               rd_hit;
   logic [CW-1:0]      new_cnt;
   logic               wr_req;

   assign tbl_full  = (cnt_ff >= MAX_CNT);
   // stored entry reaches the range start; range end reaches the stored entry
   assign reach_lo  = (rd_data.hi == ist_pkg::UMAX) || (lo_ff <= rd_data.hi + 64'd1);
   assign reach_hi  = (hi_ff == ist_pkg::UMAX) || (rd_data.lo <= hi_ff + 64'd1);
   assign cut_left  = (rd_data.lo < lo_ff);
   assign cut_right = (hi_ff < rd_data.hi);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign full_add  = !merged_ff && tbl_full;
   assign rd_hit    = (CMPW'(idx_ff) < CMPW'(cnt_ff));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign bank_sel   = sel_ff;
   assign wr_addr    = n_ff[AW-1:0];
   assign wr_en      = wr_req && (n_ff < MAX_CNT);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      cmd_in       = cmd_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      nlo_in       = nlo_ff;
      nhi_in       = nhi_ff;
      merged_in    = merged_ff;
      placed_in    = placed_ff;
      full_in      = full_ff;
      inval_in     = inval_ff;
      incl_in      = incl_ff;
      pend_in      = pend_ff;
      rdent_in     = rdent_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_addr      = i_ff[AW-1:0];
      wr_req       = 1'b0;
      wr_data      = rd_data;
      commit       = 1'b0;
      new_cnt      = n_ff;

      case (state_ff)
         // take a request, bias its bounds
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_cmd;
               lo_in     = req_lo ^ ist_pkg::SIGN_BIT;
               hi_in     = req_hi ^ ist_pkg::SIGN_BIT;
               nlo_in    = req_lo ^ ist_pkg::SIGN_BIT;
               nhi_in    = req_hi ^ ist_pkg::SIGN_BIT;
               idx_in    = req_index;
               i_in      = '0;
               n_in      = '0;
               merged_in = 1'b0;
               placed_in = 1'b0;
               full_in   = 1'b0;
               incl_in   = 1'b0;
               inval_in  = (req_cmd != ist_pkg::CMD_READ) &&
                           ((req_lo ^ ist_pkg::SIGN_BIT) > (req_hi ^ ist_pkg::SIGN_BIT));
               if ((req_cmd != ist_pkg::CMD_READ) &&
                   ((req_lo ^ ist_pkg::SIGN_BIT) > (req_hi ^ ist_pkg::SIGN_BIT))) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_RD;
               end
            end
         end

         // issue the next read, or finish the scan
         S_RD: begin
            if (cmd_ff == ist_pkg::CMD_READ) begin
               rd_addr  = AW'(idx_ff);
               state_in = S_EV;
            end else if (i_ff == cnt_ff) begin
               state_in = S_FIN;
            end else begin
               state_in = S_EV;
            end
         end

         // evaluate one entry; add and subtract stream what survives of it to the spare bank
         S_EV: begin
            state_in = S_RD;
            i_in     = i_ff + CW'(1);
            case (cmd_ff)
               ist_pkg::CMD_READ: begin
                  rdent_in = rd_data;
                  state_in = S_FIN;
               end
               ist_pkg::CMD_QUERY: begin
                  if ((rd_data.lo <= lo_ff) && (hi_ff <= rd_data.hi)) begin
                     incl_in = 1'b1;
                  end
               end
               ist_pkg::CMD_ADD: begin
                  if (placed_ff || !reach_lo) begin
                     wr_req = 1'b1;
                     n_in   = n_ff + CW'(1);
                  end else if (reach_hi) begin
                     merged_in = 1'b1;
                     if (rd_data.lo < nlo_ff) nlo_in = rd_data.lo;
                     if (rd_data.hi > nhi_ff) nhi_in = rd_data.hi;
                  end else begin
                     // place the merged range, then this entry
                     wr_req     = 1'b1;
                     wr_data.lo = nlo_ff;
                     wr_data.hi = nhi_ff;
                     n_in       = n_ff + CW'(1);
                     placed_in  = 1'b1;
                     pend_in    = rd_data;
                     state_in   = S_W2;
                  end
               end
               default: begin
                  if ((rd_data.hi < lo_ff) || (hi_ff < rd_data.lo)) begin
                     wr_req = 1'b1;
                     n_in   = n_ff + CW'(1);
                  end else begin
                     if (cut_left && cut_right && tbl_full) full_in = 1'b1;
                     pend_in.lo = hi_ff + 64'd1;
                     pend_in.hi = rd_data.hi;
                     if (cut_left) begin
                        wr_req     = 1'b1;
                        wr_data.lo = rd_data.lo;
                        wr_data.hi = lo_ff - 64'd1;
                        n_in       = n_ff + CW'(1);
                        if (cut_right) state_in = S_W2;
                     end else if (cut_right) begin
                        wr_req     = 1'b1;
                        wr_data.lo = hi_ff + 64'd1;
                        wr_data.hi = rd_data.hi;
                        n_in       = n_ff + CW'(1);
                     end
                  end
               end
            endcase
         end

         // write the held second entry
         S_W2: begin
            wr_req   = 1'b1;
            wr_data  = pend_ff;
            n_in     = n_ff + CW'(1);
            state_in = S_RD;
         end

         // close the command and load the response
         S_FIN: begin
            if (slot_free) begin
               rsp_in.status   = ist_pkg::ST_OK;
               rsp_in.included = 1'b0;
               rsp_in.valid    = 1'b0;
               rsp_in.lo       = '0;
               rsp_in.hi       = '0;
               if (inval_ff) begin
                  rsp_in.status = ist_pkg::ST_INVALID;
               end else begin
                  case (cmd_ff)
                     ist_pkg::CMD_READ: begin
                        rsp_in.valid = rd_hit;
                        if (rd_hit) begin
                           rsp_in.lo = rdent_ff.lo ^ ist_pkg::SIGN_BIT;
                           rsp_in.hi = rdent_ff.hi ^ ist_pkg::SIGN_BIT;
                        end
                     end
                     ist_pkg::CMD_QUERY: begin
                        rsp_in.included = incl_ff;
                     end
                     ist_pkg::CMD_ADD: begin
                        if (full_add) begin
                           rsp_in.status = ist_pkg::ST_FULL;
                        end else begin
                           commit = 1'b1;
                           if (!placed_ff) begin
                              wr_req     = 1'b1;
                              wr_data.lo = nlo_ff;
                              wr_data.hi = nhi_ff;
                              new_cnt    = n_ff + CW'(1);
                           end
                        end
                     end
                     default: begin
                        if (full_ff) begin
                           rsp_in.status = ist_pkg::ST_FULL;
                        end else begin
                           commit = 1'b1;
                        end
                     end
                  endcase
               end
               if (commit) begin
                  cnt_in = new_cnt;
                  sel_in = !sel_ff;
               end
               rsp_in.count = commit ? 6'(new_cnt) : 6'(cnt_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      n_ff      <= n_in;
      cmd_ff    <= cmd_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      nlo_ff    <= nlo_in;
      nhi_ff    <= nhi_in;
      merged_ff <= merged_in;
      placed_ff <= placed_in;
      full_ff   <= full_in;
      inval_ff  <= inval_in;
      incl_ff   <= incl_in;
      pend_ff   <= pend_in;
      rdent_ff  <= rdent_in;
      rsp_ff    <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("entry count above capacity");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_EV || state_ff == S_W2 || state_ff == S_FIN))
      else $error("memory write outside a scan");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("response loaded outside finish");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("accepted request left the sequencer idle");

   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      (sel_ff != $past(sel_ff)) |-> $past(state_ff == S_FIN))
      else $error("bank swapped outside a commit");

endmodule

// ===== rtl/core/interval_set_table.sv =====
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tuser: cmd; tdata: range_lo, range_hi, entry_index
// rsp      out        rsp_tvalid/rsp_tready   tdata: status, included, entry_valid, entry_lo,
//                                             entry_hi, entry_count
//
// One request at a time. A scan reads each stored entry in a read-issue and an evaluate state
// from the active bank and streams the rewritten table into the spare bank; a merge or split
// that writes two entries adds a write state (S_W2). A read does not scan the table, and an
// invalid range skips the scan. The single read port of the active bank sets the scan's pace.
// Reset empties the table at once; no clearing pass. A stalled response holds the finish
// step until taken, while the next request is already accepted and scanned.
module interval_set_table #(
   parameter int MAX_RANGES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // cmd
   input  logic [135:0] req_tdata,   // range_lo[63:0], range_hi[127:64], entry_index[132:128]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // status[1:0], included[2], entry_valid[3],
                                     // entry_lo[67:4], entry_hi[131:68], entry_count[137:132]
);

   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);

   ist_pkg::rsp_type   rsp_data;
   ist_pkg::entry_type rd_data;
   ist_pkg::entry_type rd_data0;
   ist_pkg::entry_type rd_data1;
   ist_pkg::entry_type wr_data;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic               wr_en;
   logic               bank_sel;

   ist_ctrl #(
      .MAX_RANGES (MAX_RANGES),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .req_lo     (req_tdata[63:0]),
      .req_hi     (req_tdata[127:64]),
      .req_index  (req_tdata[132:128]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .bank_sel   (bank_sel)
   );

   // bank 0: written while bank 1 is active
   ist_ram #(
      .DEPTH (MAX_RANGES),
      .AW    (AW)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && bank_sel),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   // bank 1: written while bank 0 is active
   ist_ram #(
      .DEPTH (MAX_RANGES),
      .AW    (AW)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && !bank_sel),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   // read from the active bank
   assign rd_data = bank_sel ? rd_data1 : rd_data0;

   assign rsp_tdata = {6'd0, rsp_data};

endmodule
